### rtl/dq_pkg.sv
package dq_pkg;

  // Queue capacity in words (2 to 65536)
  localparam int DEPTH = 64;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  // Action codes; unused codes behave as a peek
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_PEEK       = 3'd4
  } action_t;

  // Status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_POP_EMPTY  = 2'd1,
    STAT_PUSH_FULL  = 2'd2
  } status_t;

  localparam word_t POP_EMPTY_WORD = '1;
  localparam cnt_t  CNT_FULL = CNT_W'(DEPTH);
  localparam ptr_t  PTR_LAST = PTR_W'(DEPTH - 1);

  function automatic ptr_t wrap_inc(input ptr_t p);
    ptr_t r;
    r = (p == PTR_LAST) ? '0 : p + ptr_t'(1);
    return r;
  endfunction

  function automatic ptr_t wrap_dec(input ptr_t p);
    ptr_t r;
    r = (p == '0) ? PTR_LAST : p - ptr_t'(1);
    return r;
  endfunction

endpackage

### rtl/dq_in_if.sv
interface dq_in_if;
  import dq_pkg::*;

  logic        valid;
  logic        ready;
  logic [2:0]  action;
  word_t       value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

### rtl/dq_out_if.sv
interface dq_out_if;
  import dq_pkg::*;

  logic        valid;
  logic        ready;
  word_t       popped_value;
  word_t       front_value;
  word_t       rear_value;
  logic        empty_res;
  logic        full_res;
  logic [1:0]  status;

  modport source (output valid, output popped_value, output front_value,
                  output rear_value, output empty_res, output full_res,
                  output status, input ready);
  modport sink   (input valid, input popped_value, input front_value,
                  input rear_value, input empty_res, input full_res,
                  input status, output ready);
endinterface

### rtl/double_ended_queue_core.sv
// Channel   Direction  Handshake      Payload
// in_ch     sink       valid/ready    action[2:0], value[31:0]
// out_ch    source     valid/ready    popped_value, front_value, rear_value,
//                                     empty_res, full_res, status[1:0]
//
// A transaction is accepted in S_IDLE: that cycle updates pointers and
// issues at most one word RAM access. S_LOAD takes the registered read data
// and loads the output register. The single-port-read RAM sets this split.
// Reset clears pointers, count and valid flags; RAM contents are not cleared.
// A stalled output holds the block in its load state; a new transaction is
// accepted as soon as the previous result sits in the output register.
module double_ended_queue_core (
  input  logic            clk,
  input  logic            rst_n,
  dq_in_if.sink           in_ch,
  dq_out_if.source        out_ch
);
  import dq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_t;

  state_t  state_r, state_nxt;
  ptr_t    head_r, head_nxt;
  ptr_t    tail_r, tail_nxt;
  cnt_t    count_r, count_nxt;
  word_t   front_r, front_nxt;
  word_t   rear_r, rear_nxt;
  word_t   pop_r, pop_nxt;
  status_t stat_r, stat_nxt;
  logic    ld_front_r, ld_front_nxt;
  logic    ld_rear_r, ld_rear_nxt;

  logic    out_valid_r;
  word_t   out_pop_r, out_front_r, out_rear_r;
  logic    out_empty_r, out_full_r;
  status_t out_stat_r;

  // Word RAM
  word_t   mem [DEPTH];
  word_t   rd_r;
  logic    mem_we, mem_re;
  ptr_t    mem_wa, mem_ra;
  word_t   mem_wd;

  logic    acc, full, empty, out_load;
  word_t   front_fin, rear_fin;

  assign acc   = in_ch.valid && in_ch.ready;
  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= mem[mem_ra];
    end
  end

  // Action decode: pointer update, RAM access, cached end words
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    rear_nxt     = rear_r;
    pop_nxt      = pop_r;
    stat_nxt     = stat_r;
    ld_front_nxt = ld_front_r;
    ld_rear_nxt  = ld_rear_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wa       = head_r;
    mem_ra       = head_r;
    mem_wd       = in_ch.value;
    if (acc) begin
      pop_nxt      = '0;
      stat_nxt     = STAT_OK;
      ld_front_nxt = 1'b0;
      ld_rear_nxt  = 1'b0;
      case (in_ch.action)
        ACT_PUSH_FRONT: begin
          if (full) begin
            stat_nxt = STAT_PUSH_FULL;
          end else begin
            head_nxt  = wrap_dec(head_r);
            mem_we    = 1'b1;
            mem_wa    = wrap_dec(head_r);
            count_nxt = count_r + cnt_t'(1);
            front_nxt = in_ch.value;
            if (empty) begin
              rear_nxt = in_ch.value;
            end
          end
        end
        ACT_PUSH_REAR: begin
          if (full) begin
            stat_nxt = STAT_PUSH_FULL;
          end else begin
            tail_nxt  = wrap_inc(tail_r);
            mem_we    = 1'b1;
            mem_wa    = tail_r;
            count_nxt = count_r + cnt_t'(1);
            rear_nxt  = in_ch.value;
            if (empty) begin
              front_nxt = in_ch.value;
            end
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            pop_nxt  = POP_EMPTY_WORD;
            stat_nxt = STAT_POP_EMPTY;
          end else begin
            pop_nxt   = front_r;
            head_nxt  = wrap_inc(head_r);
            count_nxt = count_r - cnt_t'(1);
            // two left: the survivor is the cached rear word
            if (count_r == cnt_t'(2)) begin
              front_nxt = rear_r;
            end else if (count_r > cnt_t'(2)) begin
              mem_re       = 1'b1;
              mem_ra       = wrap_inc(head_r);
              ld_front_nxt = 1'b1;
            end
          end
        end
        ACT_POP_REAR: begin
          if (empty) begin
            pop_nxt  = POP_EMPTY_WORD;
            stat_nxt = STAT_POP_EMPTY;
          end else begin
            pop_nxt   = rear_r;
            tail_nxt  = wrap_dec(tail_r);
            count_nxt = count_r - cnt_t'(1);
            if (count_r == cnt_t'(2)) begin
              rear_nxt = front_r;
            end else if (count_r > cnt_t'(2)) begin
              mem_re      = 1'b1;
              mem_ra      = wrap_dec(wrap_dec(tail_r));
              ld_rear_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Load cycle: merge RAM read data into the cached end words
  assign front_fin = ld_front_r ? rd_r : front_r;
  assign rear_fin  = ld_rear_r  ? rd_r : rear_r;
  assign out_load  = (state_r == S_LOAD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, pointers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      ld_front_r  <= 1'b0;
      ld_rear_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      ld_front_r <= ld_front_nxt;
      ld_rear_r  <= ld_rear_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    pop_r  <= pop_nxt;
    stat_r <= stat_nxt;
    if (out_load) begin
      front_r     <= front_fin;
      rear_r      <= rear_fin;
      out_pop_r   <= pop_r;
      out_front_r <= empty ? word_t'(0) : front_fin;
      out_rear_r  <= empty ? word_t'(0) : rear_fin;
      out_empty_r <= empty;
      out_full_r  <= full;
      out_stat_r  <= stat_r;
    end else begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = out_pop_r;
  assign out_ch.front_value  = out_front_r;
  assign out_ch.rear_value   = out_rear_r;
  assign out_ch.empty_res    = out_empty_r;
  assign out_ch.full_res     = out_full_r;
  assign out_ch.status       = out_stat_r;

endmodule
